/* src/poc_pkg.sv */
// shared types and constants of the pattern occurrence counter
package poc_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int SYMBOL_BITS = 32;

    localparam int VALUE_W = 32;
    localparam int IDX_W   = $clog2(MAX_PATTERN);
    localparam int FILL_W  = $clog2(MAX_PATTERN + 1);
    localparam int CFG_W   = 5;
    localparam int COUNT_W = 32;

    localparam int IN_DATA_W  = ((VALUE_W + IDX_W + 7) / 8) * 8;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = ((COUNT_W + 7) / 8) * 8;
    localparam int OUT_USER_W = 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic {
        OP_PATTERN = 1'b0,
        OP_TEXT    = 1'b1
    } t_opcode;

    typedef logic [SYMBOL_BITS-1:0] t_symbol;

    typedef struct packed {
        t_opcode            opcode;
        logic [VALUE_W-1:0] value;
        logic [IDX_W-1:0]   pattern_index;
        logic               first_of_text;
    } t_item;

    typedef struct packed {
        logic               match_here;
        logic [COUNT_W-1:0] match_count;
    } t_result;

endpackage

/* src/pattern_occurrence_counter_unit.sv */
// top level of the pattern occurrence counter: stream in, count matches, stream out
//
//  channel   | direction | payload                                   | handshake
//  ----------+-----------+-------------------------------------------+----------------
//  s_axis    | in        | tdata: value, pattern_index; tuser: opcode,| tvalid/tready
//            |           |   first_of_text                           |
//  m_axis    | out       | tdata: match_count; tuser: match_here     | tvalid/tready
//  cfg       | in        | pattern_length                            | write enable
//
// one transaction per cycle sustained while m_axis is not stalled; a text symbol's result
// passes the input register at acceptance, then the compare and the result register
// pattern writes produce no result and take one slot in the input register
// synchronous active-low reset clears the valids, fill count, match count and sets
// pattern_length to one; the pattern store holds nothing defined until written
// a stall on m_axis holds the result register and backs up into the input register
module pattern_occurrence_counter_unit
    import poc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write: pattern_length
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_W-1:0]      i_cfg_wr_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [31:0] value, [35:32] pattern_index, [39:36] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] opcode, [1] first_of_text
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [31:0] match_count
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // [0] match_here
    output logic [OUT_USER_W-1:0] m_axis_tuser
);

    logic    advance;      // result register can take a new value this cycle
    logic    item_valid;   // input register holds a transaction
    t_item   item;
    logic    fire;         // held transaction is processed this cycle
    t_result result;

    assign fire = item_valid && advance;

    // stage one: capture the incoming transaction
    poc_in_reg u_in_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_advance     (advance),
        .o_item_valid  (item_valid),
        .o_item        (item)
    );

    // stage two: write the pattern store, or shift the window, compare against the pattern, update counters
    poc_match_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_fire        (fire),
        .i_item        (item),
        .o_result      (result)
    );

    // result register, loaded only for text symbols
    poc_out_reg u_out_reg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (item_valid),
        .i_result_valid (item.opcode == OP_TEXT),
        .i_result       (result),
        .o_advance      (advance),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser)
    );

endmodule

/* src/poc_in_reg.sv */
// input register stage: captures one transaction and holds it until processed
module poc_in_reg
    import poc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    input  logic                  i_advance,
    output logic                  o_item_valid,
    output t_item                 o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign s_axis_tready = !r_valid || i_advance;

    always_comb begin
        n_item.opcode        = t_opcode'(s_axis_tuser[0]);
        n_item.first_of_text = s_axis_tuser[1];
        n_item.value         = s_axis_tdata[VALUE_W-1:0];
        n_item.pattern_index = s_axis_tdata[VALUE_W+IDX_W-1:VALUE_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item <= n_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

/* src/poc_match_core.sv */
// pattern store, text window, fill and match counters, parallel window compare
module poc_match_core
    import poc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    input  logic             i_fire,
    input  t_item            i_item,
    output t_result          o_result
);

    logic [CFG_W-1:0]   r_length;
    t_symbol            r_pattern [MAX_PATTERN];
    t_symbol            r_window  [MAX_PATTERN];
    t_symbol            n_window  [MAX_PATTERN];
    logic [FILL_W-1:0]  r_fill;
    logic [FILL_W-1:0]  n_fill;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic [COUNT_W-1:0] base_count;
    logic [IDX_W-1:0]   len_m1;
    logic [MAX_PATTERN-1:0] hit_len;
    logic               hit;
    t_symbol            sym;
    logic               text_fire;

    assign sym       = i_item.value[SYMBOL_BITS-1:0];
    assign text_fire = i_fire && (i_item.opcode == OP_TEXT);

    // effective length minus one, zero acts as one, clamp at the window depth
    always_comb begin
        if (r_length == '0) begin
            len_m1 = '0;
        end else if (r_length > CFG_W'(MAX_PATTERN)) begin
            len_m1 = IDX_W'(MAX_PATTERN - 1);
        end else begin
            len_m1 = IDX_W'(r_length - CFG_W'(1));
        end
    end

    always_comb begin
        n_window[0] = sym;
        for (int i = 1; i < MAX_PATTERN; i++) begin
            n_window[i] = r_window[i-1];
        end
    end

    always_comb begin
        if (i_item.first_of_text) begin
            n_fill = FILL_W'(1);
        end else if (r_fill == FILL_W'(MAX_PATTERN)) begin
            n_fill = r_fill;
        end else begin
            n_fill = r_fill + FILL_W'(1);
        end
    end

    // one match flag per candidate length, window slot j meets pattern slot l-j
    always_comb begin
        for (int l = 0; l < MAX_PATTERN; l++) begin
            hit_len[l] = (n_fill > FILL_W'(l));
            for (int j = 0; j < MAX_PATTERN; j++) begin
                if (j <= l) begin
                    if (n_window[j] != r_pattern[l-j]) begin
                        hit_len[l] = 1'b0;
                    end
                end
            end
        end
    end

    assign hit        = hit_len[len_m1];
    assign base_count = i_item.first_of_text ? '0 : r_count;
    assign n_count    = (hit && (base_count != COUNT_MAX)) ? base_count + COUNT_W'(1)
                                                           : base_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= CFG_W'(1);
        end else if (i_cfg_wr_en) begin
            r_length <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_count <= '0;
        end else if (text_fire) begin
            r_fill  <= n_fill;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (text_fire) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
                r_window[i] <= n_window[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && (i_item.opcode == OP_PATTERN)) begin
            r_pattern[i_item.pattern_index] <= sym;
        end
    end

    assign o_result.match_here  = hit;
    assign o_result.match_count = n_count;

endmodule

/* src/poc_out_reg.sv */
// result register: holds one result until the downstream side takes it
module poc_out_reg
    import poc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  logic                   i_result_valid,
    input  t_result                i_result,
    output logic                   o_advance,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    output logic [OUT_USER_W-1:0]  m_axis_tuser
);

    logic    r_valid;
    t_result r_result;

    assign o_advance = !r_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_load && i_result_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_load && i_result_valid) begin
            r_result <= i_result;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_result.match_count);
    assign m_axis_tuser  = r_result.match_here;

endmodule

/* dv/testbench.sv */
// self-checking testbench for the pattern occurrence counter unit
module testbench;
    import poc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // cycles with no transaction on either stream before the run is abandoned
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    // pipeline depth plus margin; pattern writes leave no result behind them
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned TARGET_ITEMS = 1300;

    // predicts every result from its own copy of the pattern, window and counters
    class match_scoreboard;
        t_symbol            pattern_mem[MAX_PATTERN];
        t_symbol            window[MAX_PATTERN];
        int unsigned        fill;
        logic [COUNT_W-1:0] occurrences;
        logic [CFG_W-1:0]   length_reg;
        t_result            pending[$];
        int unsigned        errors;
        int unsigned        results_seen;
        int unsigned        matches_seen;

        function new();
            foreach (pattern_mem[i]) pattern_mem[i] = '0;
            length_reg   = CFG_W'(1);
            errors       = 0;
            results_seen = 0;
            matches_seen = 0;
            clear_text();
        endfunction

        function void clear_text();
            foreach (window[i]) window[i] = '0;
            fill        = 0;
            occurrences = '0;
        endfunction

        function void set_length(logic [CFG_W-1:0] len);
            length_reg = len;
        endfunction

        // zero acts as one, anything past the store depth acts as the full depth
        function int unsigned active_length();
            if (length_reg == 0) return 1;
            if (length_reg > MAX_PATTERN) return MAX_PATTERN;
            return length_reg;
        endfunction

        function void note_input(t_item it);
            int unsigned len;
            logic        hit;
            t_result     res;
            if (it.opcode == OP_PATTERN) begin
                // first flag has no effect on a pattern write
                pattern_mem[it.pattern_index] = it.value;
                return;
            end
            if (it.first_of_text) clear_text();
            for (int i = MAX_PATTERN - 1; i > 0; i--) window[i] = window[i-1];
            window[0] = it.value;
            if (fill < MAX_PATTERN) fill++;
            len = active_length();
            hit = (fill >= len);
            // pattern element k lines up with the symbol len-1-k places back
            for (int k = 0; k < len; k++) begin
                if (window[len-1-k] != pattern_mem[k]) hit = 1'b0;
            end
            if (hit && occurrences != COUNT_MAX) occurrences++;
            if (hit) matches_seen++;
            res.match_here  = hit;
            res.match_count = occurrences;
            pending.push_back(res);
        endfunction

        function void check_result(t_result got);
            t_result want;
            results_seen++;
            if (pending.size() == 0) begin
                $error("unexpected result: match_here %0b match_count %0d",
                       got.match_here, got.match_count);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.match_here !== want.match_here) begin
                $error("match_here mismatch: expected %0b, actual %0b",
                       want.match_here, got.match_here);
                errors++;
            end
            if (got.match_count !== want.match_count) begin
                $error("match_count mismatch: expected %0d, actual %0d",
                       want.match_count, got.match_count);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_W-1:0]      i_cfg_wr_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // [31:0] value, [35:32] pattern_index, [39:36] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // [0] opcode, [1] first_of_text
    logic [IN_USER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [31:0] match_count
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // [0] match_here
    logic [OUT_USER_W-1:0] m_axis_tuser;

    match_scoreboard sb = new;

    // sender state: transactions left in the current burst
    int unsigned burst_left = 0;
    int unsigned items_sent = 0;
    int unsigned phases_run = 0;

    pattern_occurrence_counter_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_item make_item(t_opcode op, t_symbol val, logic [IDX_W-1:0] idx,
                                        logic first);
        t_item it;
        it.opcode        = op;
        it.value         = val;
        it.pattern_index = idx;
        it.first_of_text = first;
        return it;
    endfunction

    // one transaction on s_axis; valid stays high across back-to-back items of a burst
    task automatic send_item(input t_item it);
        int unsigned gap;
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
            // long bursts give stretches with no sender idling at all
            burst_left = ($urandom_range(0, 9) < 3) ? $urandom_range(40, 100)
                                                    : $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'({it.pattern_index, it.value});
        s_axis_tuser  <= {it.first_of_text, it.opcode};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_input(it);
        burst_left--;
        items_sent++;
    endtask

    // sender holds off until every expected result is back and the pipe is empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [CFG_W-1:0] len);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= len;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_length(len);
    endtask

    // one setting of pattern_length: load a pattern, then a stream of texts that
    // mostly carry copies of it, with noise symbols, stray first flags and pattern
    // rewrites mixed in
    task automatic run_phase(input logic [CFG_W-1:0] len, input bit keep_text);
        t_symbol     alphabet[3];
        t_symbol     extremes[4];
        int unsigned eff;
        int unsigned budget;
        int unsigned done;
        int unsigned text_len;
        int unsigned in_text;
        int unsigned pick;
        logic        first_pending;
        drain();
        write_length(len);
        phases_run++;
        eff = sb.active_length();
        extremes = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};
        alphabet[0] = $urandom;
        alphabet[1] = extremes[$urandom_range(0, 3)];
        alphabet[2] = $urandom;
        for (int k = 0; k < eff; k++) begin
            send_item(make_item(OP_PATTERN, alphabet[$urandom_range(0, 2)], IDX_W'(k),
                                1'($urandom_range(0, 1))));
        end
        budget = $urandom_range(80, 160);
        done = 0;
        // a continued text sees the new length applied to the old window
        first_pending = !keep_text;
        while (done < budget) begin
            text_len = $urandom_range(10, 60);
            in_text = 0;
            while (in_text < text_len) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    for (int k = 0; k < eff; k++) begin
                        send_item(make_item(OP_TEXT, sb.pattern_mem[k], IDX_W'($urandom),
                                            first_pending));
                        first_pending = 1'b0;
                    end
                    in_text += eff;
                end else if (pick < 85) begin
                    send_item(make_item(OP_TEXT, alphabet[$urandom_range(0, 2)],
                                        IDX_W'($urandom), first_pending));
                    first_pending = 1'b0;
                    in_text++;
                end else if (pick < 92) begin
                    // full-range symbol, sometimes restarting the text halfway
                    send_item(make_item(OP_TEXT, $urandom, IDX_W'($urandom),
                                        first_pending || ($urandom_range(0, 4) == 0)));
                    first_pending = 1'b0;
                    in_text++;
                end else begin
                    // pattern rewrite in the middle of a text
                    send_item(make_item(OP_PATTERN,
                                        $urandom_range(0, 1) ? t_symbol'($urandom)
                                                             : alphabet[$urandom_range(0, 2)],
                                        IDX_W'($urandom_range(0, MAX_PATTERN - 1)),
                                        1'($urandom_range(0, 1))));
                    in_text++;
                end
            end
            done += in_text;
            first_pending = 1'b1;
        end
    endtask

    // receiver: switches between always ready, random ready and long stalls
    initial begin
        int unsigned stall_left;
        int unsigned mode;
        int unsigned cyc;
        t_result     got;
        stall_left = 0;
        mode = 0;
        cyc = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got.match_here  = m_axis_tuser[0];
                got.match_count = m_axis_tdata[COUNT_W-1:0];
                sb.check_result(got);
            end
            if (cyc % 64 == 0) mode = $urandom_range(0, 2);
            cyc++;
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (mode == 0) begin
                m_axis_tready <= 1'b1;
            end else if (mode == 1) begin
                m_axis_tready <= ($urandom_range(0, 9) < 7);
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(2, 12);
            end
        end
    end

    // watchdog: too long with no transaction on either side means a hang
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic [CFG_W-1:0] lengths[10];
        logic [CFG_W-1:0] len;
        int unsigned      phase;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: fill the whole store first so no unwritten entry is ever compared
        send_item(make_item(OP_PATTERN, 32'h8000_0000, 4'd0, 1'b0));
        send_item(make_item(OP_PATTERN, 32'h7fff_ffff, 4'd1, 1'b1));
        send_item(make_item(OP_PATTERN, 32'h0000_0000, 4'd2, 1'b0));
        send_item(make_item(OP_PATTERN, 32'hffff_ffff, 4'd3, 1'b0));
        for (int k = 4; k < MAX_PATTERN; k++) begin
            send_item(make_item(OP_PATTERN, $urandom, IDX_W'(k), 1'b0));
        end
        // reset length is one: single-symbol matches against the most negative value
        send_item(make_item(OP_TEXT, 32'h8000_0000, 4'd0, 1'b1));
        send_item(make_item(OP_TEXT, 32'h8000_0000, 4'd15, 1'b0));
        send_item(make_item(OP_TEXT, 32'h7fff_ffff, 4'd0, 1'b0));
        // first flag on a pattern write leaves the text running
        send_item(make_item(OP_PATTERN, 32'h7fff_ffff, 4'd0, 1'b1));
        send_item(make_item(OP_TEXT, 32'h7fff_ffff, 4'd0, 1'b0));
        // first flag on a text symbol restarts the count
        send_item(make_item(OP_TEXT, 32'h0000_0000, 4'd0, 1'b1));
        send_item(make_item(OP_TEXT, 32'h7fff_ffff, 4'd0, 1'b0));

        // extremes first: one, full depth, zero, all ones, just past the depth
        lengths = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd2, 5'd8, 5'd3, 5'd15, 5'd5};
        phase = 0;
        while (items_sent < TARGET_ITEMS) begin
            len = (phase < 10) ? lengths[phase] : CFG_W'($urandom_range(0, 31));
            run_phase(len, (phase > 0) && ($urandom_range(0, 1) == 1));
            phase++;
        end

        drain();
        $display("covered %0d transactions in %0d length settings", items_sent, phases_run);
        $display("checked %0d results, %0d of them matches", sb.results_seen,
                 sb.matches_seen);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
